// File: rtl/cbf_pkg.sv
// Shared types, constants and helpers for the cubic Bezier flattener.
`default_nettype none
package cbf_pkg;

    // Coordinate width (Q16.16) and fixed-point one for the curve parameter t
    localparam int CBF_COORD_W      = 32;
    localparam int CBF_SAT_W        = 32;
    localparam int CBF_T_W          = 17;
    localparam int CBF_W_W          = 18;
    localparam int CBF_TERM_W       = CBF_COORD_W + CBF_W_W + 1 - 16;
    localparam int CBF_SUM_W        = CBF_TERM_W + 2;
    localparam int CBF_SEG_W        = 7;
    localparam int CBF_MAX_SEGMENTS = 64;
    localparam logic [CBF_T_W-1:0] CBF_T_ONE = CBF_T_W'(17'h10000);

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_CUBIC = 2'd1,
        OP_AUTO  = 2'd2,
        OP_RSVD  = 2'd3
    } t_cbf_op;

    typedef struct packed {
        t_cbf_op                        op;
        logic signed [CBF_COORD_W-1:0]  end_x;
        logic signed [CBF_COORD_W-1:0]  end_y;
        logic signed [CBF_COORD_W-1:0]  ctrl1_x;
        logic signed [CBF_COORD_W-1:0]  ctrl1_y;
        logic signed [CBF_COORD_W-1:0]  ctrl2_x;
        logic signed [CBF_COORD_W-1:0]  ctrl2_y;
        logic [CBF_SEG_W-1:0]           segments;
    } t_cbf_in;

    typedef struct packed {
        logic signed [CBF_COORD_W-1:0]  point_x;
        logic signed [CBF_COORD_W-1:0]  point_y;
        logic                           last;
    } t_cbf_out;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
    } t_cbf_cmd;

    // Datapath to controller
    typedef struct packed {
        logic op_skip;
        logic div_busy;
        logic pipe_busy;
        logic adv;
        logic last_pt;
    } t_cbf_stat;

    // Clamp a wide sum to the signed coordinate range
    function automatic logic signed [CBF_COORD_W-1:0] cbf_sat(
        input logic signed [CBF_SUM_W-1:0] v
    );
        logic signed [CBF_SUM_W-1:0] hi;
        logic signed [CBF_SUM_W-1:0] lo;
        hi = CBF_SUM_W'((65'sd1 <<< (CBF_SAT_W - 1)) - 65'sd1);
        lo = -hi - CBF_SUM_W'(1);
        if (v > hi) begin
            return hi[CBF_COORD_W-1:0];
        end else if (v < lo) begin
            return lo[CBF_COORD_W-1:0];
        end
        return v[CBF_COORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/cbf_if.sv
// Valid/ready channel interfaces for path requests and emitted points.
`default_nettype none
interface cbf_in_if import cbf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cbf_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbf_out_if import cbf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cbf_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/cbf_div.sv
// Restoring divider: computes 65536 / N and 65536 % N, one quotient bit per cycle.
`default_nettype none
module cbf_div import cbf_pkg::*; #(
    parameter int NW = 7
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [NW-1:0]   i_divisor,
    output logic                 o_busy,
    output logic [CBF_T_W-1:0]   o_quot,
    output logic [NW-1:0]        o_rem
);
    localparam int CNT_W = $clog2(CBF_T_W);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [NW-1:0]      r_d;
    logic [CBF_T_W-1:0] r_dvd;
    logic [NW-1:0]      r_rem;
    logic [NW:0]        part;
    logic               ge;

    // Shift in the next dividend bit and try to subtract
    assign part = {r_rem, r_dvd[CBF_T_W-1]};
    assign ge   = (part >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(CBF_T_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Dividend register collects quotient bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_divisor;
            r_dvd <= CBF_T_ONE;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[CBF_T_W-2:0], ge};
            r_rem <= ge ? NW'(part - {1'b0, r_d}) : NW'(part);
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// File: rtl/cbf_ctrl.sv
// Sequencer: accepts requests, waits for the step division, issues curve points.
`default_nettype none
module cbf_ctrl import cbf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_cbf_stat  i_stat,
    output t_cbf_cmd        o_cmd
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ISSUE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Take a request only once earlier points have left the pipeline
    assign o_in_ready  = (r_state == ST_IDLE) && !i_stat.pipe_busy;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd.load  = accept && !i_stat.op_skip;
    assign o_cmd.issue = (r_state == ST_ISSUE) && i_stat.adv;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_stat.div_busy) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (o_cmd.issue && i_stat.last_pt) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// File: rtl/cbf_dpath.sv
// Datapath: pen and control points, t stepping, Bernstein weight pipeline, output register.
`default_nettype none
module cbf_dpath import cbf_pkg::*; #(
    parameter int MAX_SEGMENTS = CBF_MAX_SEGMENTS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cbf_in    i_in_data,
    input  wire t_cbf_cmd   i_cmd,
    output t_cbf_stat       o_stat,
    cbf_out_if.source       o_out
);
    localparam int NW = $clog2(MAX_SEGMENTS + 1);
    localparam int CW = (NW > CBF_SEG_W) ? NW : CBF_SEG_W;
    localparam int PW = 2 * CBF_T_W;

    // Pen, control points and segment count
    logic signed [CBF_COORD_W-1:0] r_pen_x, r_pen_y;
    logic signed [CBF_COORD_W-1:0] r_px [4];
    logic signed [CBF_COORD_W-1:0] r_py [4];
    logic [NW-1:0]                 r_n;
    logic [NW-1:0]                 n_n;
    logic [CW-1:0]                 seg_w;
    logic signed [CBF_COORD_W:0]   mid_sum;
    logic signed [CBF_COORD_W-1:0] mid;

    // Step division
    logic                          div_busy;
    logic [CBF_T_W-1:0]            quot;
    logic [NW-1:0]                 rem;

    // t stepping
    logic [CBF_T_W-1:0]            r_acc_q;
    logic [NW-1:0]                 r_acc_r;
    logic [NW-1:0]                 r_idx;
    logic [NW:0]                   rem_sum;
    logic                          wrap;
    logic [CBF_T_W-1:0]            t_next;
    logic                          last_pt;

    // Pipeline stages
    logic                          adv;
    logic                          r_s0_v, r_s0_last;
    logic [CBF_T_W-1:0]            r_s0_t, r_s0_s;
    logic                          r_s1_v, r_s1_last;
    logic [CBF_T_W-1:0]            r_s1_t, r_s1_s, r_s1_ss, r_s1_st, r_s1_tt;
    logic                          r_s2_v, r_s2_last;
    logic [CBF_W_W-1:0]            r_w [4];
    logic                          r_s3_v, r_s3_last;
    logic signed [CBF_TERM_W-1:0]  r_tx [4];
    logic signed [CBF_TERM_W-1:0]  r_ty [4];
    logic                          r_out_v, r_out_last;
    logic signed [CBF_COORD_W-1:0] r_out_x, r_out_y;

    logic [PW-1:0]                 p_ss, p_st, p_tt;
    logic [PW-1:0]                 p_w1, p_w2, p_w3, p_w4;
    logic [CBF_T_W-1:0]            h_w2, h_w3;
    logic signed [CBF_COORD_W+CBF_W_W:0] p_x [4];
    logic signed [CBF_COORD_W+CBF_W_W:0] p_y [4];
    logic signed [CBF_SUM_W-1:0]   sum_x, sum_y;

    // Clamp the segment count to 1..MAX_SEGMENTS; a line-to is one point
    assign seg_w = CW'(i_in_data.segments);
    always_comb begin
        if (i_in_data.op == OP_LINE || seg_w == '0) begin
            n_n = NW'(1);
        end else if (seg_w > CW'(MAX_SEGMENTS)) begin
            n_n = NW'(MAX_SEGMENTS);
        end else begin
            n_n = NW'(seg_w);
        end
    end

    // Vertical midpoint, rounded toward minus infinity
    assign mid_sum = (CBF_COORD_W + 1)'(r_pen_y) + (CBF_COORD_W + 1)'(i_in_data.end_y);
    assign mid     = CBF_COORD_W'(mid_sum >>> 1);

    // Capture the curve on a request; the pen moves to the end point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
            r_pen_y <= '0;
        end else if (i_cmd.load) begin
            r_pen_x <= i_in_data.end_x;
            r_pen_y <= i_in_data.end_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n     <= n_n;
            r_px[0] <= r_pen_x;
            r_py[0] <= r_pen_y;
            r_px[3] <= i_in_data.end_x;
            r_py[3] <= i_in_data.end_y;
            unique case (i_in_data.op)
                OP_CUBIC: begin
                    r_px[1] <= i_in_data.ctrl1_x;
                    r_py[1] <= i_in_data.ctrl1_y;
                    r_px[2] <= i_in_data.ctrl2_x;
                    r_py[2] <= i_in_data.ctrl2_y;
                end
                OP_AUTO: begin
                    r_px[1] <= r_pen_x;
                    r_py[1] <= mid;
                    r_px[2] <= i_in_data.end_x;
                    r_py[2] <= mid;
                end
                default: begin
                    r_px[1] <= i_in_data.end_x;
                    r_py[1] <= i_in_data.end_y;
                    r_px[2] <= i_in_data.end_x;
                    r_py[2] <= i_in_data.end_y;
                end
            endcase
        end
    end

    cbf_div #(.NW(NW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.load),
        .i_divisor (n_n),
        .o_busy    (div_busy),
        .o_quot    (quot),
        .o_rem     (rem)
    );

    // Advance t = floor(i*65536/N) by quotient and remainder
    assign rem_sum = {1'b0, r_acc_r} + {1'b0, rem};
    assign wrap    = (rem_sum >= {1'b0, r_n});
    assign t_next  = CBF_T_W'({1'b0, r_acc_q} + {1'b0, quot} + (CBF_T_W + 1)'(wrap));
    assign last_pt = ({1'b0, r_idx} + (NW + 1)'(1)) == {1'b0, r_n};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_q <= '0;
            r_acc_r <= '0;
            r_idx   <= '0;
        end else if (i_cmd.issue) begin
            r_acc_q <= t_next;
            r_acc_r <= wrap ? NW'(rem_sum - {1'b0, r_n}) : NW'(rem_sum);
            r_idx   <= r_idx + NW'(1);
        end
    end

    // The whole pipeline moves unless the output register is held
    assign adv = !r_out_v || o_out.ready;

    // Products of the first and second stage
    assign p_ss = r_s0_s * r_s0_s;
    assign p_st = r_s0_s * r_s0_t;
    assign p_tt = r_s0_t * r_s0_t;
    assign p_w1 = r_s1_ss * r_s1_s;
    assign p_w2 = r_s1_ss * r_s1_t;
    assign p_w3 = r_s1_st * r_s1_t;
    assign p_w4 = r_s1_tt * r_s1_t;
    assign h_w2 = p_w2[CBF_T_W+15:16];
    assign h_w3 = p_w3[CBF_T_W+15:16];

    // Weighted coordinate products of the third stage
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p_x[k] = $signed({1'b0, r_w[k]}) * r_px[k];
            p_y[k] = $signed({1'b0, r_w[k]}) * r_py[k];
        end
    end

    // Sum of the four floored terms
    assign sum_x = CBF_SUM_W'(r_tx[0]) + CBF_SUM_W'(r_tx[1])
                 + CBF_SUM_W'(r_tx[2]) + CBF_SUM_W'(r_tx[3]);
    assign sum_y = CBF_SUM_W'(r_ty[0]) + CBF_SUM_W'(r_ty[1])
                 + CBF_SUM_W'(r_ty[2]) + CBF_SUM_W'(r_ty[3]);

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_s0_v  <= i_cmd.issue;
            r_s1_v  <= r_s0_v;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_t    <= t_next;
            r_s0_s    <= CBF_T_ONE - t_next;
            r_s0_last <= last_pt;

            r_s1_t    <= r_s0_t;
            r_s1_s    <= r_s0_s;
            r_s1_ss   <= p_ss[CBF_T_W+15:16];
            r_s1_st   <= p_st[CBF_T_W+15:16];
            r_s1_tt   <= p_tt[CBF_T_W+15:16];
            r_s1_last <= r_s0_last;

            r_w[0]    <= CBF_W_W'(p_w1[CBF_T_W+15:16]);
            r_w[1]    <= (CBF_W_W'(h_w2) << 1) + CBF_W_W'(h_w2);
            r_w[2]    <= (CBF_W_W'(h_w3) << 1) + CBF_W_W'(h_w3);
            r_w[3]    <= CBF_W_W'(p_w4[CBF_T_W+15:16]);
            r_s2_last <= r_s1_last;

            for (int k = 0; k < 4; k++) begin
                r_tx[k] <= p_x[k][CBF_COORD_W+CBF_W_W:16];
                r_ty[k] <= p_y[k][CBF_COORD_W+CBF_W_W:16];
            end
            r_s3_last <= r_s2_last;

            r_out_x    <= cbf_sat(sum_x);
            r_out_y    <= cbf_sat(sum_y);
            r_out_last <= r_s3_last;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.data.point_x = r_out_x;
    assign o_out.data.point_y = r_out_y;
    assign o_out.data.last    = r_out_last;

    assign o_stat.op_skip   = (i_in_data.op == OP_RSVD);
    assign o_stat.div_busy  = div_busy;
    assign o_stat.pipe_busy = r_s0_v || r_s1_v || r_s2_v || r_s3_v;
    assign o_stat.adv       = adv;
    assign o_stat.last_pt   = last_pt;
endmodule
`default_nettype wire

// File: rtl/cubic_bezier_flattener_core.sv
// Cubic Bezier flattener: path requests in, flattened Q16.16 points out.
//
// Input channel i_in carries one path request: line-to, cubic bezier-to, or
// bezier-to with controls on the vertical midpoint. Output channel o_out
// carries the emitted points; last marks the final point of a request.
// Each request first runs a restoring division for the step of t, then
// issues one point per cycle, while the receiver does not stall, into a
// four-stage pipeline (a t stage and three multiply stages) whose
// sum-and-clamp result loads the output register. A line-to takes the same
// path as a one-point curve. Op code 3 is accepted and dropped without a
// point. The divider's one-bit-per-cycle loop and the one-point-per-cycle
// issue set the rate; a new request is taken once the previous request's
// points have reached the output register.
// Reset clears the pen point to zero, empties the pipeline and the output
// register. When the receiver stalls, the whole pipeline and the issue
// counter hold; no point is dropped.
`default_nettype none
module cubic_bezier_flattener_core import cbf_pkg::*; #(
    parameter int MAX_SEGMENTS = CBF_MAX_SEGMENTS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbf_in_if.sink     i_in,
    cbf_out_if.source  o_out
);
    t_cbf_cmd  cmd;
    t_cbf_stat stat;
    logic      in_ready;

    cbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cbf_dpath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in.data),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_out     (o_out)
    );

    assign i_in.ready = in_ready;
endmodule
`default_nettype wire

// File: rtl/cbf_chk.sv
// Port-level checker for the flattener, bound to the top level.
`default_nettype none
module cbf_chk import cbf_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     i_in_ready,
    input wire t_cbf_op  i_in_op,
    input wire logic     i_out_valid,
    input wire logic     i_out_ready,
    input wire logic     i_out_last
);
    // Output register comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled point stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // A working request holds ready low in the cycle after it is taken
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op != OP_RSVD |=> !i_in_ready)
        else $error("request taken while previous one starts");

    // Ready only when every earlier point but a final one has left
    a_ready_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last)
        else $error("request ready with curve points still pending");
endmodule

bind cubic_bezier_flattener_core cbf_chk u_cbf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.data.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.data.last)
);
`default_nettype wire

// File: dv/cubic_bezier_flattener_core_test.sv
// Self-checking testbench for the cubic Bezier flattener: random and directed path requests.
`timescale 1ns / 1ps
module cubic_bezier_flattener_core_test;
    import cbf_pkg::*;

    localparam logic signed [CBF_COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CBF_COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [CBF_COORD_W-1:0] UNIT      = 32'sh0001_0000;
    localparam longint SAT_HI = (longint'(1) <<< (CBF_COORD_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam int RANDOM_REQS = 105;
    localparam int CALM_REQS   = 20;
    // A 64-point curve runs the step division and then its points, and every
    // point may wait out a receiver stall; this limit is many times what it needs.
    localparam int STUCK_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        t_cbf_in req;
        bit      wait_drain;
    } t_path_job;

    logic clk;
    logic rst_n;

    cbf_in_if  in_ch();
    cbf_out_if out_ch();

    cubic_bezier_flattener_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_path_job   path_jobs[$];
    t_cbf_out    due_points[$];
    logic signed [CBF_COORD_W-1:0] pen_x;
    logic signed [CBF_COORD_W-1:0] pen_y;
    int unsigned points_predicted;
    int unsigned points_seen;
    int unsigned points_checked;
    int unsigned reqs_taken;
    int unsigned op_count[4];
    int unsigned errors;
    int          send_gap;
    int          recv_stall;
    logic        calm = 1'b0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Pick a coordinate: extremes, full range, or a small value around zero
    function automatic logic signed [CBF_COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            1, 2: return $urandom;
            default: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic void add_req(
        t_cbf_op op,
        logic signed [CBF_COORD_W-1:0] ex, ey, c1x, c1y, c2x, c2y,
        logic [CBF_SEG_W-1:0] seg,
        bit drain = 1'b0
    );
        t_path_job job;
        job.req.op       = op;
        job.req.end_x    = ex;
        job.req.end_y    = ey;
        job.req.ctrl1_x  = c1x;
        job.req.ctrl1_y  = c1y;
        job.req.ctrl2_x  = c2x;
        job.req.ctrl2_y  = c2y;
        job.req.segments = seg;
        job.wait_drain   = drain;
        path_jobs = {path_jobs, job};
    endfunction

    // Expected points of one request; advance the pen to the last one
    function automatic void flatten_path(input t_cbf_in req);
        longint   ax[4];
        longint   ay[4];
        longint   w[4];
        longint   nseg, t, s, ss, st, tt, sx, sy;
        t_cbf_out pt;
        if (req.op == OP_RSVD) begin
            return;
        end
        if (req.op == OP_LINE) begin
            pen_x = req.end_x;
            pen_y = req.end_y;
            pt.point_x = req.end_x;
            pt.point_y = req.end_y;
            pt.last    = 1'b1;
            due_points = {due_points, pt};
            points_predicted++;
            return;
        end
        ax[0] = longint'(pen_x);
        ay[0] = longint'(pen_y);
        ax[3] = longint'(req.end_x);
        ay[3] = longint'(req.end_y);
        if (req.op == OP_CUBIC) begin
            ax[1] = longint'(req.ctrl1_x);
            ay[1] = longint'(req.ctrl1_y);
            ax[2] = longint'(req.ctrl2_x);
            ay[2] = longint'(req.ctrl2_y);
        end else begin
            // controls sit on the vertical midpoint, rounded toward minus infinity
            ax[1] = ax[0];
            ax[2] = ax[3];
            ay[1] = (ay[0] + ay[3]) >>> 1;
            ay[2] = ay[1];
        end
        nseg = longint'(req.segments);
        if (nseg == 0) begin
            nseg = 1;
        end
        if (nseg > CBF_MAX_SEGMENTS) begin
            nseg = CBF_MAX_SEGMENTS;
        end
        for (longint i = 1; i <= nseg; i++) begin
            t  = (i * 65536) / nseg;
            s  = 65536 - t;
            ss = (s * s) >> 16;
            st = (s * t) >> 16;
            tt = (t * t) >> 16;
            w[0] = (ss * s) >> 16;
            w[1] = 3 * ((ss * t) >> 16);
            w[2] = 3 * ((st * t) >> 16);
            w[3] = (tt * t) >> 16;
            sx = 0;
            sy = 0;
            for (int k = 0; k < 4; k++) begin
                sx += (w[k] * ax[k]) >>> 16;
                sy += (w[k] * ay[k]) >>> 16;
            end
            sx = (sx > SAT_HI) ? SAT_HI : (sx < SAT_LO) ? SAT_LO : sx;
            sy = (sy > SAT_HI) ? SAT_HI : (sy < SAT_LO) ? SAT_LO : sy;
            pt.point_x = sx[CBF_COORD_W-1:0];
            pt.point_y = sy[CBF_COORD_W-1:0];
            pt.last    = (i == nseg);
            due_points = {due_points, pt};
            points_predicted++;
            if (i == nseg) begin
                pen_x = pt.point_x;
                pen_y = pt.point_y;
            end
        end
    endfunction

    // Driver: present queued requests, idle in bursts, hold drain points
    always @(posedge clk) begin
        bit took;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            pen_x = '0;
            pen_y = '0;
            send_gap = 0;
        end else begin
            took = in_ch.valid && in_ch.ready;
            if (took) begin
                flatten_path(in_ch.data);
                reqs_taken++;
                op_count[in_ch.data.op]++;
            end
            if (out_ch.valid && out_ch.ready) begin
                points_seen++;
            end
            if (!in_ch.valid || took) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (path_jobs.size() == 0 ||
                             (path_jobs[0].wait_drain && points_seen != points_predicted)) begin
                    in_ch.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= path_jobs[0].req;
                    void'(path_jobs.pop_front());
                end
            end
            calm <= (path_jobs.size() <= CALM_REQS);
        end
    end

    // Monitor: check each point against the oldest expectation, stall in bursts
    always @(posedge clk) begin
        t_cbf_out want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_points.size() == 0) begin
                    $display("%0t: point with nothing due, got x=%h y=%h last=%b", $time,
                             out_ch.data.point_x, out_ch.data.point_y, out_ch.data.last);
                    errors++;
                end else begin
                    want = due_points.pop_front();
                    points_checked++;
                    if (out_ch.data.point_x !== want.point_x) begin
                        $display("%0t: point_x expected %h actual %h", $time,
                                 want.point_x, out_ch.data.point_x);
                        errors++;
                    end
                    if (out_ch.data.point_y !== want.point_y) begin
                        $display("%0t: point_y expected %h actual %h", $time,
                                 want.point_y, out_ch.data.point_y);
                        errors++;
                    end
                    if (out_ch.data.last !== want.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, out_ch.data.last);
                        errors++;
                    end
                end
            end
            if (calm) begin
                out_ch.ready <= 1'b1;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                recv_stall = $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: drop the run if no request or point moves for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus, reset and end of run
    initial begin
        int       busy;
        int       pick;
        t_cbf_op  op;
        logic [CBF_SEG_W-1:0] seg;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        rst_n        = 1'b0;

        // curve straight from the reset pen
        add_req(OP_CUBIC, 10 * UNIT, 20 * UNIT, 2 * UNIT, 30 * UNIT, 8 * UNIT, -5 * UNIT, 7'd4);
        // zero segments emit the end point only
        add_req(OP_AUTO, -(7 * UNIT) / 2, 7 * UNIT, rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), 7'd0);
        // line-to ignores controls and segment count
        add_req(OP_LINE, COORD_MAX, COORD_MAX, rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), 7'd127);
        add_req(OP_CUBIC, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                7'd64);
        // segment counts above the maximum saturate
        add_req(OP_AUTO, COORD_MAX, COORD_MAX, '0, '0, '0, '0, 7'd65);
        add_req(OP_LINE, COORD_MIN, COORD_MAX, '0, '0, '0, '0, 7'd0);
        add_req(OP_AUTO, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                7'd127);
        // unused op code leaves the pen alone
        add_req(OP_RSVD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), 7'd5);
        add_req(OP_AUTO, UNIT, -3 * UNIT, '0, '0, '0, '0, 7'd3);
        add_req(OP_LINE, '0, '0, '0, '0, '0, '0, 7'd0, 1'b1);
        add_req(OP_CUBIC, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), 7'd1);
        add_req(OP_CUBIC, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), 7'd2);
        add_req(OP_LINE, -1, -1, -1, -1, -1, -1, 7'h7F);
        // odd negative sum for the midpoint
        add_req(OP_AUTO, 5 * UNIT, -2, '0, '0, '0, '0, 7'd7);
        add_req(OP_CUBIC, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), 7'd100);
        add_req(OP_RSVD, COORD_MIN, COORD_MAX, -1, '0, COORD_MAX, COORD_MIN, 7'd0);
        add_req(OP_LINE, rand_coord(), rand_coord(), '0, '0, '0, '0, 7'd1);
        add_req(OP_AUTO, rand_coord(), rand_coord(), '0, '0, '0, '0, 7'd64);

        // random requests: mostly short curves, a few long or saturating ones
        busy = 0;
        while (busy < RANDOM_REQS) begin
            pick = $urandom_range(0, 19);
            op = (pick < 5) ? OP_LINE : (pick < 12) ? OP_CUBIC : (pick < 18) ? OP_AUTO : OP_RSVD;
            pick = $urandom_range(0, 19);
            seg = (pick < 14) ? CBF_SEG_W'($urandom_range(0, 12)) :
                  (pick < 18) ? CBF_SEG_W'($urandom_range(13, 64)) :
                                CBF_SEG_W'($urandom_range(65, 127));
            add_req(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), seg, $urandom_range(0, 29) == 0);
            if (op != OP_RSVD) begin
                busy++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all requests taken and all points back, then let the pipe drain
        do begin
            @(negedge clk);
        end while (path_jobs.size() != 0 || in_ch.valid || due_points.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d requests: %0d line-to, %0d cubic, %0d midpoint curves, %0d unused op.",
                 reqs_taken, op_count[OP_LINE], op_count[OP_CUBIC], op_count[OP_AUTO],
                 op_count[OP_RSVD]);
        $display("Checked %0d points with %0d mismatches.", points_checked, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
